// File: hw/rtl/stst_pkg.sv
// Shared types and constants for the software timer slot table.
// Holds the sequencer states, result kinds, action codes and field widths.
// No dependencies.
`default_nettype none

package stst_pkg;

    localparam int SLOT_COUNT_DEF  = 8;
    localparam int OWNER_WIDTH_DEF = 16;

    localparam int OWNER_ID_W   = 16;
    localparam int COUNT_W      = 8;
    localparam int SLOT_INDEX_W = 3;
    localparam int KIND_W       = 2;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_ADD  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED    = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_FIRED    = 2'd2
    } kind_t;

endpackage

`default_nettype wire

// File: hw/rtl/software_timer_slot_table_core.sv
// Top level of the software timer slot table: sequencer, busy bits, tick count.
// Depends on stst_pkg and stst_slot_store.
//
// Usage: an item is taken at a rising edge where start is high and busy is low.
// action selects a tick (count advances, expired slots fire) or an add (arm or
// re-arm the timer of owner_id to expire delay_ticks ticks from now).
// Results come out one beat at a time: result_valid is high for exactly one
// cycle per result, with kind, slot_index, fired_owner, now_count and last.
// The receiver cannot stall; every beat is taken in the cycle it is shown.
// An add gives exactly one result; a tick gives one result per expired slot,
// in ascending slot order, or none at all when nothing expires.
// Timing: every item walks the whole table one slot per cycle through the
// single read port of the slot store, so busy stays high through the scan and
// the done state. The next item is taken at the earliest at the edge that ends
// the first cycle with busy low, so a new item is never taken before the last
// one is through. The add result appears in the first cycle after busy falls.
// A fired result is held until the next firing slot is compared and shows in
// the cycle after; the final one appears in the first cycle after busy falls.
// Reset clears the tick count and all busy bits at once; no clearing pass.
`default_nettype none

module software_timer_slot_table_core
    import stst_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int OWNER_WIDTH = OWNER_WIDTH_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    action,
    input  wire logic [OWNER_ID_W-1:0]   owner_id,
    input  wire logic [COUNT_W-1:0]      delay_ticks,
    output logic                         result_valid,
    output logic      [KIND_W-1:0]       kind,
    output logic      [SLOT_INDEX_W-1:0] slot_index,
    output logic      [OWNER_ID_W-1:0]   fired_owner,
    output logic      [COUNT_W-1:0]      now_count,
    output logic                         last
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    state_t                  state_reg, state_next;
    logic [COUNT_W-1:0]      tick_count_reg, tick_count_next;
    logic [SLOT_COUNT-1:0]   slot_busy_reg, slot_busy_next;

    logic                    action_reg, action_next;
    logic [OWNER_WIDTH-1:0]  req_owner_reg, req_owner_next;
    logic [COUNT_W-1:0]      req_delay_reg, req_delay_next;

    logic [IDX_W-1:0]        issue_idx_reg, issue_idx_next;
    logic                    issue_on_reg, issue_on_next;
    logic [IDX_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                    cmp_on_reg, cmp_on_next;

    logic                    hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    logic                    free_found_reg, free_found_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;

    logic                    pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    logic [OWNER_WIDTH-1:0]  pend_owner_reg, pend_owner_next;

    logic                    res_valid_reg, res_valid_next;
    kind_t                   res_kind_reg, res_kind_next;
    logic [IDX_W-1:0]        res_idx_reg, res_idx_next;
    logic [OWNER_WIDTH-1:0]  res_owner_reg, res_owner_next;
    logic [COUNT_W-1:0]      res_count_reg, res_count_next;
    logic                    res_last_reg, res_last_next;

    logic                    mem_we;
    logic [IDX_W-1:0]        mem_wr_idx;
    logic [COUNT_W-1:0]      mem_wr_expiry;
    logic [OWNER_WIDTH-1:0]  rd_owner;
    logic [COUNT_W-1:0]      rd_expiry;

    logic [OWNER_WIDTH+OWNER_ID_W-1:0]  owner_in_ext;
    logic [OWNER_WIDTH+OWNER_ID_W-1:0]  res_owner_ext;
    logic [IDX_W+SLOT_INDEX_W-1:0]      res_idx_ext;

    assign owner_in_ext  = {{OWNER_WIDTH{1'b0}}, owner_id};
    assign res_owner_ext = {{OWNER_ID_W{1'b0}}, res_owner_reg};
    assign res_idx_ext   = {{SLOT_INDEX_W{1'b0}}, res_idx_reg};

    stst_slot_store #(
        .SLOT_COUNT  (SLOT_COUNT),
        .OWNER_WIDTH (OWNER_WIDTH)
    ) u_store (
        .clk       (clk),
        .wr_en     (mem_we),
        .wr_idx    (mem_wr_idx),
        .wr_owner  (req_owner_reg),
        .wr_expiry (mem_wr_expiry),
        .rd_idx    (issue_idx_reg),
        .rd_owner  (rd_owner),
        .rd_expiry (rd_expiry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tick_count_reg <= '0;
            slot_busy_reg  <= '0;
            issue_on_reg   <= 1'b0;
            cmp_on_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            slot_busy_reg  <= slot_busy_next;
            issue_on_reg   <= issue_on_next;
            cmp_on_reg     <= cmp_on_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        req_owner_reg  <= req_owner_next;
        req_delay_reg  <= req_delay_next;
        issue_idx_reg  <= issue_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        pend_idx_reg   <= pend_idx_next;
        pend_owner_reg <= pend_owner_next;
        res_kind_reg   <= res_kind_next;
        res_idx_reg    <= res_idx_next;
        res_owner_reg  <= res_owner_next;
        res_count_reg  <= res_count_next;
        res_last_reg   <= res_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        tick_count_next = tick_count_reg;
        slot_busy_next  = slot_busy_reg;
        action_next     = action_reg;
        req_owner_next  = req_owner_reg;
        req_delay_next  = req_delay_reg;
        issue_idx_next  = issue_idx_reg;
        issue_on_next   = issue_on_reg;
        // The read issued this cycle is compared in the next one.
        cmp_idx_next    = issue_idx_reg;
        cmp_on_next     = (state_reg == ST_SCAN) && issue_on_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_owner_next = pend_owner_reg;
        res_valid_next  = 1'b0;
        res_kind_next   = res_kind_reg;
        res_idx_next    = res_idx_reg;
        res_owner_next  = res_owner_reg;
        res_count_next  = tick_count_reg;
        res_last_next   = res_last_reg;
        mem_we          = 1'b0;
        mem_wr_idx      = hit_idx_reg;
        mem_wr_expiry   = tick_count_reg + req_delay_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next      = ST_SCAN;
                    action_next     = action;
                    req_owner_next  = owner_in_ext[OWNER_WIDTH-1:0];
                    req_delay_next  = delay_ticks;
                    issue_idx_next  = '0;
                    issue_on_next   = 1'b1;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    if (action == ACT_TICK)
                    begin
                        tick_count_next = tick_count_reg + COUNT_W'(1);
                    end
                end
            end

            ST_SCAN:
            begin
                if (issue_on_reg)
                begin
                    if (issue_idx_reg == LAST_IDX)
                    begin
                        issue_on_next = 1'b0;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg + IDX_W'(1);
                    end
                end

                if (cmp_on_reg)
                begin
                    if (action_reg == ACT_ADD)
                    begin
                        if (slot_busy_reg[cmp_idx_reg] && rd_owner == req_owner_reg
                            && !hit_found_reg)
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = cmp_idx_reg;
                        end
                        if (!slot_busy_reg[cmp_idx_reg] && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                    end
                    else if (slot_busy_reg[cmp_idx_reg] && rd_expiry == tick_count_reg)
                    begin
                        // Hold each firing slot back until the next one is found
                        // so the final one can carry last.
                        slot_busy_next[cmp_idx_reg] = 1'b0;
                        if (pend_valid_reg)
                        begin
                            res_valid_next = 1'b1;
                            res_kind_next  = KIND_FIRED;
                            res_idx_next   = pend_idx_reg;
                            res_owner_next = pend_owner_reg;
                            res_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = cmp_idx_reg;
                        pend_owner_next = rd_owner;
                    end

                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                state_next = ST_IDLE;
                if (action_reg == ACT_ADD)
                begin
                    res_valid_next = 1'b1;
                    res_owner_next = req_owner_reg;
                    res_last_next  = 1'b1;
                    if (hit_found_reg || free_found_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_wr_idx = hit_found_reg ? hit_idx_reg : free_idx_reg;
                        slot_busy_next[mem_wr_idx] = 1'b1;
                        res_kind_next = KIND_ADDED;
                        res_idx_next  = mem_wr_idx;
                    end
                    else
                    begin
                        res_kind_next = KIND_REJECTED;
                        res_idx_next  = '0;
                    end
                end
                else if (pend_valid_reg)
                begin
                    res_valid_next  = 1'b1;
                    res_kind_next   = KIND_FIRED;
                    res_idx_next    = pend_idx_reg;
                    res_owner_next  = pend_owner_reg;
                    res_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign kind         = res_kind_reg;
    assign slot_index   = res_idx_ext[SLOT_INDEX_W-1:0];
    assign fired_owner  = res_owner_ext[OWNER_ID_W-1:0];
    assign now_count    = res_count_reg;
    assign last         = res_last_reg;

    // An accepted item always makes the sequencer busy after the accepting edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

    // Add outcomes are always the only beat of their item.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_ADDED || kind == KIND_REJECTED) |-> last)
    else $error("add result without last");

    // No fired beat may be left waiting once the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_valid_reg)
    else $error("pending fired result left behind");

    // A fired beat reports a slot that has just been freed.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_kind_reg == KIND_FIRED |-> !slot_busy_reg[res_idx_reg])
    else $error("fired slot still marked busy");

endmodule

`default_nettype wire

// File: hw/rtl/stst_slot_store.sv
// Owner and expiry storage for the timer slots: one write port and one
// registered read port. Depends on stst_pkg for the count width.
`default_nettype none

module stst_slot_store
    import stst_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int OWNER_WIDTH = OWNER_WIDTH_DEF,
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
)
(
    input  wire logic                   clk,
    input  wire logic                   wr_en,
    input  wire logic [IDX_W-1:0]       wr_idx,
    input  wire logic [OWNER_WIDTH-1:0] wr_owner,
    input  wire logic [COUNT_W-1:0]     wr_expiry,
    input  wire logic [IDX_W-1:0]       rd_idx,
    output logic      [OWNER_WIDTH-1:0] rd_owner,
    output logic      [COUNT_W-1:0]     rd_expiry
);

    logic [OWNER_WIDTH-1:0] owner_mem  [SLOT_COUNT];
    logic [COUNT_W-1:0]     expiry_mem [SLOT_COUNT];
    logic [OWNER_WIDTH-1:0] rd_owner_reg;
    logic [COUNT_W-1:0]     rd_expiry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            owner_mem[wr_idx]  <= wr_owner;
            expiry_mem[wr_idx] <= wr_expiry;
        end
        rd_owner_reg  <= owner_mem[rd_idx];
        rd_expiry_reg <= expiry_mem[rd_idx];
    end

    assign rd_owner  = rd_owner_reg;
    assign rd_expiry = rd_expiry_reg;

endmodule

`default_nettype wire
